// ===== design/iatf_pkg.sv =====
// ============================================================================
// iatf_pkg
// shared types, character codes and decimal tables of the address formatter
// ============================================================================
`default_nettype none

package iatf_pkg;

    localparam logic [1:0] KIND_V4 = 2'd1;
    localparam logic [1:0] KIND_V6 = 2'd2;

    localparam logic [15:0] OCTET_MAX = 16'd255;

    localparam logic [2:0] OCTET_LAST   = 3'd3;
    localparam logic [2:0] GROUP_LAST   = 3'd7;
    localparam logic [2:0] DEC_LAST_IDX = 3'd4;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_BR_OPEN = 8'h5b;
    localparam logic [7:0] CH_BR_CLOSE = 8'h5d;
    localparam logic [7:0] CH_NONE    = 8'h00;

    // k times the decimal place, place index 0 is ten thousands
    localparam logic [16:0] DEC_STEP [5][10] = '{
        '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
          17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
        '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
          17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
        '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
          17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
        '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
          17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
        '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4,
          17'd5, 17'd6, 17'd7, 17'd8, 17'd9}
    };

    typedef enum logic [1:0] {
        CLS_INVALID = 2'd0,
        CLS_V4      = 2'd1,
        CLS_V6      = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t             cls;
        logic [7:0][15:0] grp;
        logic [15:0]      port;
        logic             with_port;
        logic             has_run;
        logic [2:0]       run_first;
        logic [3:0]       run_next;
    } desc_t;

    // place index of the leading decimal digit
    function automatic logic [2:0] dec_start(input logic [15:0] v);
        logic [2:0] idx;
        if (v >= 16'd10000)
        begin
            idx = 3'd0;
        end
        else if (v >= 16'd1000)
        begin
            idx = 3'd1;
        end
        else if (v >= 16'd100)
        begin
            idx = 3'd2;
        end
        else if (v >= 16'd10)
        begin
            idx = 3'd3;
        end
        else
        begin
            idx = DEC_LAST_IDX;
        end
        return idx;
    endfunction

    // position of the leading nonzero nibble, 0 for a zero group
    function automatic logic [1:0] hex_start(input logic [15:0] v);
        logic [1:0] pos;
        if (v[15:12] != 4'd0)
        begin
            pos = 2'd3;
        end
        else if (v[11:8] != 4'd0)
        begin
            pos = 2'd2;
        end
        else if (v[7:4] != 4'd0)
        begin
            pos = 2'd1;
        end
        else
        begin
            pos = 2'd0;
        end
        return pos;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
        begin
            c = CH_ZERO + {4'd0, n};
        end
        else
        begin
            c = CH_A_LOWER - 8'd10 + {4'd0, n};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/iatf_front.sv =====
// ============================================================================
// iatf_front
// accepts an address, checks its kind and octets, finds the zero run to fold
// ============================================================================
`default_nettype none

module iatf_front (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           addr_kind,
    input  logic [7:0][15:0]     groups,
    input  logic [15:0]          port_number,
    input  logic                 with_port,
    input  logic                 q_full,
    output logic                 q_push,
    output iatf_pkg::desc_t      q_data
);
    import iatf_pkg::*;

    typedef struct packed {
        logic       has;
        logic [2:0] first;
        logic [3:0] next;
    } run_t;

    function automatic run_t find_run(input logic [7:0][15:0] g);
        run_t       r;
        logic [3:0] best_len;
        logic [2:0] best_start;
        logic [3:0] run_len;
        logic [2:0] run_start;
        logic       has;
        best_len   = 4'd0;
        best_start = 3'd0;
        run_len    = 4'd0;
        run_start  = 3'd0;
        has        = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (g[i] == 16'd0)
            begin
                if (run_len == 4'd0)
                begin
                    run_start = 3'(i);
                end
                run_len = run_len + 4'd1;
            end
            if (g[i] != 16'd0 || i == 7)
            begin
                if (run_len > best_len && run_len > 4'd1)
                begin
                    best_len   = run_len;
                    best_start = run_start;
                    has        = 1'b1;
                end
                run_len = 4'd0;
            end
        end
        r.has   = has;
        r.first = best_start;
        r.next  = {1'b0, best_start} + best_len;
        return r;
    endfunction

    logic octets_ok;
    run_t run;

    assign octets_ok = (groups[0] <= OCTET_MAX) && (groups[1] <= OCTET_MAX)
                    && (groups[2] <= OCTET_MAX) && (groups[3] <= OCTET_MAX);
    assign run = find_run(groups);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data.grp       = groups;
        q_data.port      = port_number;
        q_data.with_port = with_port;
        q_data.has_run   = run.has;
        q_data.run_first = run.first;
        q_data.run_next  = run.next;
        if (addr_kind == KIND_V4 && octets_ok)
        begin
            q_data.cls = CLS_V4;
        end
        else if (addr_kind == KIND_V6)
        begin
            q_data.cls = CLS_V6;
        end
        else
        begin
            q_data.cls = CLS_INVALID;
        end
    end

endmodule

`default_nettype wire

// ===== design/iatf_queue.sv =====
// ============================================================================
// iatf_queue
// short descriptor queue between the classifying front and the text back
// ============================================================================
`default_nettype none

module iatf_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iatf_pkg::desc_t push_data,
    input  logic            pop,
    output iatf_pkg::desc_t head,
    output logic            empty,
    output logic            full
);
    import iatf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/iatf_back.sv =====
// ============================================================================
// iatf_back
// character sequencer: walks one descriptor and emits its text one character
// per transfer through an output register
// ============================================================================
`default_nettype none

module iatf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  iatf_pkg::desc_t head,
    input  logic            head_valid,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      text_char,
    output logic            last_char,
    output logic            invalid
);
    import iatf_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_INVAL  = 11'b000_0000_0010,
        ST_BOPEN  = 11'b000_0000_0100,
        ST_LEAD   = 11'b000_0000_1000,
        ST_GROUP  = 11'b000_0001_0000,
        ST_GSEP   = 11'b000_0010_0000,
        ST_ZCOL   = 11'b000_0100_0000,
        ST_BCLOSE = 11'b000_1000_0000,
        ST_PCOL   = 11'b001_0000_0000,
        ST_DEC    = 11'b010_0000_0000,
        ST_DOT    = 11'b100_0000_0000
    } st_t;

    typedef struct packed {
        st_t        st;
        logic [1:0] nib;
    } entry_t;

    function automatic entry_t group_entry(input desc_t d, input logic [2:0] gi);
        entry_t e;
        if (d.has_run && d.run_first == gi)
        begin
            e.st  = ST_ZCOL;
            e.nib = 2'd0;
        end
        else
        begin
            e.st  = ST_GROUP;
            e.nib = hex_start(d.grp[gi]);
        end
        return e;
    endfunction

    st_t         st_reg, st_next;
    desc_t       desc_reg, desc_next;
    logic [2:0]  grp_reg, grp_next;
    logic [1:0]  nib_reg, nib_next;
    logic [15:0] dec_val_reg, dec_val_next;
    logic [2:0]  dec_idx_reg, dec_idx_next;
    logic        dec_port_reg, dec_port_next;
    logic        out_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic        bad_reg;

    logic        out_free;
    logic        fire;
    logic        adv;
    logic [7:0]  ch;
    logic        is_last;
    logic        is_bad;
    logic [3:0]  dig;
    logic [3:0]  nibble;
    logic [2:0]  grp_inc;
    entry_t      ent;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = (st_reg != ST_IDLE) && out_free;
    assign adv      = (st_reg == ST_IDLE) ? head_valid : out_free;
    assign pop      = (st_reg == ST_IDLE) && head_valid;
    assign grp_inc  = grp_reg + 3'd1;
    assign nibble   = desc_reg.grp[grp_reg][{nib_reg, 2'b00} +: 4];

    always_comb
    begin
        dig = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if ({1'b0, dec_val_reg} >= DEC_STEP[dec_idx_reg][k])
            begin
                dig = 4'(k);
            end
        end
    end

    always_comb
    begin
        st_next       = st_reg;
        desc_next     = desc_reg;
        grp_next      = grp_reg;
        nib_next      = nib_reg;
        dec_val_next  = dec_val_reg;
        dec_idx_next  = dec_idx_reg;
        dec_port_next = dec_port_reg;
        ch            = CH_NONE;
        is_last       = 1'b0;
        is_bad        = 1'b0;
        ent           = group_entry(desc_reg, 3'd0);
        unique case (st_reg)
            ST_IDLE:
            begin
                desc_next     = head;
                grp_next      = 3'd0;
                dec_port_next = 1'b0;
                dec_val_next  = head.grp[0];
                dec_idx_next  = dec_start(head.grp[0]);
                ent           = group_entry(head, 3'd0);
                unique case (head.cls)
                    CLS_V4:
                    begin
                        st_next = ST_DEC;
                    end
                    CLS_V6:
                    begin
                        if (head.with_port)
                        begin
                            st_next = ST_BOPEN;
                        end
                        else if (head.has_run && head.run_first == 3'd0)
                        begin
                            st_next = ST_LEAD;
                        end
                        else
                        begin
                            st_next  = ent.st;
                            nib_next = ent.nib;
                        end
                    end
                    default:
                    begin
                        st_next = ST_INVAL;
                    end
                endcase
            end
            ST_INVAL:
            begin
                is_bad  = 1'b1;
                is_last = 1'b1;
                st_next = ST_IDLE;
            end
            ST_BOPEN:
            begin
                ch = CH_BR_OPEN;
                if (desc_reg.has_run && desc_reg.run_first == 3'd0)
                begin
                    st_next = ST_LEAD;
                end
                else
                begin
                    st_next  = ent.st;
                    nib_next = ent.nib;
                end
            end
            ST_LEAD:
            begin
                ch       = CH_COLON;
                st_next  = ent.st;
                nib_next = ent.nib;
            end
            ST_GROUP:
            begin
                ch = hex_ascii(nibble);
                if (nib_reg != 2'd0)
                begin
                    nib_next = nib_reg - 2'd1;
                end
                else if (grp_reg != GROUP_LAST)
                begin
                    st_next = ST_GSEP;
                end
                else if (desc_reg.with_port)
                begin
                    st_next = ST_BCLOSE;
                end
                else
                begin
                    is_last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            ST_GSEP:
            begin
                ch       = CH_COLON;
                ent      = group_entry(desc_reg, grp_inc);
                grp_next = grp_inc;
                st_next  = ent.st;
                nib_next = ent.nib;
            end
            ST_ZCOL:
            begin
                ch = CH_COLON;
                if (!desc_reg.run_next[3])
                begin
                    ent      = group_entry(desc_reg, desc_reg.run_next[2:0]);
                    grp_next = desc_reg.run_next[2:0];
                    st_next  = ent.st;
                    nib_next = ent.nib;
                end
                else if (desc_reg.with_port)
                begin
                    st_next = ST_BCLOSE;
                end
                else
                begin
                    is_last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            ST_BCLOSE:
            begin
                ch      = CH_BR_CLOSE;
                st_next = ST_PCOL;
            end
            ST_PCOL:
            begin
                ch            = CH_COLON;
                st_next       = ST_DEC;
                dec_val_next  = desc_reg.port;
                dec_idx_next  = dec_start(desc_reg.port);
                dec_port_next = 1'b1;
            end
            ST_DEC:
            begin
                ch           = CH_ZERO + {4'd0, dig};
                dec_val_next = 16'({1'b0, dec_val_reg} - DEC_STEP[dec_idx_reg][dig]);
                if (dec_idx_reg != DEC_LAST_IDX)
                begin
                    dec_idx_next = dec_idx_reg + 3'd1;
                end
                else if (dec_port_reg)
                begin
                    is_last = 1'b1;
                    st_next = ST_IDLE;
                end
                else if (grp_reg != OCTET_LAST)
                begin
                    st_next = ST_DOT;
                end
                else if (desc_reg.with_port)
                begin
                    st_next = ST_PCOL;
                end
                else
                begin
                    is_last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            ST_DOT:
            begin
                ch           = CH_DOT;
                grp_next     = grp_inc;
                dec_val_next = desc_reg.grp[grp_inc];
                dec_idx_next = dec_start(desc_reg.grp[grp_inc]);
                st_next      = ST_DEC;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                st_reg <= st_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            desc_reg     <= desc_next;
            grp_reg      <= grp_next;
            nib_reg      <= nib_next;
            dec_val_reg  <= dec_val_next;
            dec_idx_reg  <= dec_idx_next;
            dec_port_reg <= dec_port_next;
        end
        if (fire)
        begin
            char_reg <= ch;
            last_reg <= is_last;
            bad_reg  <= is_bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;
    assign invalid   = bad_reg;

endmodule

`default_nettype wire

// ===== design/ip_address_text_formatter.sv =====
// ============================================================================
// ip_address_text_formatter
// prints an IPv4 or IPv6 address, optionally with a port, as ASCII text
// ============================================================================
//
//   channel   signals                                        dir
//   input     in_valid, in_stall, addr_kind, group0..group7,  in
//             port_number, with_port
//   output    out_valid, out_stall, text_char, last_char,     out
//             invalid
//
// the back sequencer emits one character per cycle unless out_stall holds it,
// and takes the next descriptor from the queue in its idle state only after
// the last character of the current one; the longest text is 47 characters
// the front classifies and queues up to QUEUE_DEPTH addresses ahead
// reset clears the queue, the sequencer state and the output valid
// out_stall, while out_valid is high, holds the output register and freezes
// the sequencer outside its idle state; in_stall rises only while the queue is full
// ============================================================================
`default_nettype none

module ip_address_text_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  addr_kind,
    input  logic [15:0] group0,
    input  logic [15:0] group1,
    input  logic [15:0] group2,
    input  logic [15:0] group3,
    input  logic [15:0] group4,
    input  logic [15:0] group5,
    input  logic [15:0] group6,
    input  logic [15:0] group7,
    input  logic [15:0] port_number,
    input  logic        with_port,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  text_char,
    output logic        last_char,
    output logic        invalid
);
    import iatf_pkg::*;

    logic [7:0][15:0] groups;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    desc_t            q_data;
    desc_t            q_head;

    assign groups = {group7, group6, group5, group4, group3, group2, group1, group0};

    iatf_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .addr_kind   (addr_kind),
        .groups      (groups),
        .port_number (port_number),
        .with_port   (with_port),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    iatf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    iatf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (!q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .text_char  (text_char),
        .last_char  (last_char),
        .invalid    (invalid)
    );

`ifndef SYNTHESIS
    a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid) |-> (last_char && text_char == CH_NONE))
        else $error("invalid result is not a single null character");

    a_valid_printable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !invalid) |-> (text_char != CH_NONE))
        else $error("valid text carries a null character");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("descriptor fetched from an empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_full && !in_stall))
        else $error("descriptor written into a full queue");
`endif

endmodule

`default_nettype wire
